>>> rtl/utf8_stream_decoder_assert.svh
// Assertion macros for the UTF-8 stream decoder, clocked on clk and held off in reset.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8D_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8 decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define U8D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 decoder check failed");

`endif

>>> rtl/utf8d_pkg.sv
// Shared types, constants and check functions for the UTF-8 stream decoder.
package utf8d_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POINT_W = 31;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_CTRL  = 1'b1;

  localparam logic [POINT_W-1:0] REPLACEMENT = 31'h0000_FFFD;

  typedef struct packed {
    logic                kind;
    logic [POINT_W-1:0]  code_point;
    logic                last;
  } result_t;

  // Handshake status of the output stage as seen by the top level.
  typedef struct packed {
    logic room;
    logic hold_busy;
  } out_status_t;

  // Smallest code point allowed for a sequence of the given length.
  function automatic logic [POINT_W-1:0] least_point(input logic [LEN_W-1:0] len);
    logic [POINT_W-1:0] least;
    case (len)
      3'd2:    least = 31'h0000_0080;
      3'd3:    least = 31'h0000_0800;
      3'd4:    least = 31'h0001_0000;
      3'd5:    least = 31'h0020_0000;
      3'd6:    least = 31'h0400_0000;
      default: least = '0;
    endcase
    return least;
  endfunction

  // Overlong forms, surrogates and the two noncharacters become the replacement.
  function automatic logic [POINT_W-1:0] check_point(input logic [POINT_W-1:0] cp,
                                                     input logic [LEN_W-1:0]   len);
    logic [POINT_W-1:0] res;
    res = cp;
    if (cp < least_point(len)) begin
      res = REPLACEMENT;
    end else if ((cp >= 31'h0000_D800 && cp <= 31'h0000_DFFF) ||
                 cp == 31'h0000_FFFE || cp == 31'h0000_FFFF) begin
      res = REPLACEMENT;
    end
    return res;
  endfunction

endpackage

>>> rtl/utf8d_decode.sv
// Sequence state and single-pass decode of one registered byte into up to two results.
module utf8d_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [utf8d_pkg::BYTE_W-1:0] byte_in,
  input  logic                        fire,
  output logic [1:0]                  num_res,
  output utf8d_pkg::result_t          res0,
  output utf8d_pkg::result_t          res1
);
  import utf8d_pkg::*;

  logic [LEN_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic [LEN_W-1:0]   seq_length_r, seq_length_nxt;
  logic [POINT_W-1:0] partial_r, partial_nxt;
  logic [POINT_W-1:0] shifted;
  logic [POINT_W-1:0] byte_ext;

  assign shifted  = {partial_r[POINT_W-7:0], byte_in[5:0]};
  assign byte_ext = {{(POINT_W-BYTE_W){1'b0}}, byte_in};

  always_comb begin
    num_res        = 2'd0;
    res0           = '{kind: KIND_POINT, code_point: REPLACEMENT, last: 1'b1};
    res1           = '{kind: KIND_POINT, code_point: byte_ext, last: 1'b1};
    bytes_left_nxt = bytes_left_r;
    seq_length_nxt = seq_length_r;
    partial_nxt    = partial_r;
    if (byte_in < 8'h20) begin
      num_res        = 2'd1;
      res0           = '{kind: KIND_CTRL, code_point: byte_ext, last: 1'b1};
      bytes_left_nxt = '0;
    end else if (byte_in < 8'h80) begin
      bytes_left_nxt = '0;
      if (bytes_left_r != '0) begin
        // The broken sequence is reported before the ASCII character itself.
        num_res = 2'd2;
        res0    = '{kind: KIND_POINT, code_point: REPLACEMENT, last: 1'b0};
      end else begin
        num_res = 2'd1;
        res0    = '{kind: KIND_POINT, code_point: byte_ext, last: 1'b1};
      end
    end else if (byte_in < 8'hC0) begin
      if (bytes_left_r == '0) begin
        num_res = 2'd1;
      end else begin
        partial_nxt    = shifted;
        bytes_left_nxt = bytes_left_r - 3'd1;
        if (bytes_left_r == 3'd1) begin
          num_res = 2'd1;
          res0    = '{kind: KIND_POINT, code_point: check_point(shifted, seq_length_r),
                      last: 1'b1};
        end
      end
    end else if (byte_in >= 8'hFE) begin
      num_res = 2'd1;
    end else begin
      if (byte_in < 8'hE0) begin
        partial_nxt    = {26'd0, byte_in[4:0]};
        seq_length_nxt = 3'd2;
      end else if (byte_in < 8'hF0) begin
        partial_nxt    = {27'd0, byte_in[3:0]};
        seq_length_nxt = 3'd3;
      end else if (byte_in < 8'hF8) begin
        partial_nxt    = {28'd0, byte_in[2:0]};
        seq_length_nxt = 3'd4;
      end else if (byte_in < 8'hFC) begin
        partial_nxt    = {29'd0, byte_in[1:0]};
        seq_length_nxt = 3'd5;
      end else begin
        partial_nxt    = {30'd0, byte_in[0]};
        seq_length_nxt = 3'd6;
      end
      bytes_left_nxt = seq_length_nxt - 3'd1;
      if (bytes_left_r != '0) begin
        num_res = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      seq_length_r <= '0;
      partial_r    <= '0;
    end else if (fire) begin
      bytes_left_r <= bytes_left_nxt;
      seq_length_r <= seq_length_nxt;
      partial_r    <= partial_nxt;
    end
  end

endmodule

>>> rtl/utf8d_out_stage.sv
// Output register with a hold register for the second result of a byte.
module utf8d_out_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [1:0]                    num_res,
  input  utf8d_pkg::result_t            res0,
  input  utf8d_pkg::result_t            res1,
  input  logic                          out_ready,
  output logic                          out_valid,
  output utf8d_pkg::result_t            out_res,
  output utf8d_pkg::out_status_t        status
);
  import utf8d_pkg::*;

  logic    out_valid_r;
  result_t out_res_r;
  logic    hold_valid_r;
  result_t hold_res_r;
  logic    out_free;

  assign out_free         = !out_valid_r || out_ready;
  assign status.room      = out_free && !hold_valid_r;
  assign status.hold_busy = hold_valid_r;
  assign out_valid        = out_valid_r;
  assign out_res          = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else if (out_free) begin
      if (hold_valid_r) begin
        out_valid_r  <= 1'b1;
        hold_valid_r <= 1'b0;
      end else if (push && num_res != 2'd0) begin
        out_valid_r  <= 1'b1;
        hold_valid_r <= (num_res == 2'd2);
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_valid_r) begin
        out_res_r <= hold_res_r;
      end else begin
        out_res_r  <= res0;
        hold_res_r <= res1;
      end
    end
  end

endmodule

>>> rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder: one byte a cycle in when not stalled, a decoded code point or
// control word out. A byte accepted goes into the input register and its first result
// then into the output register; back-pressure can stall between them. A byte giving
// two results holds the input until the single output register drains the hold register.
// Reset (synchronous, rst_n low) empties both stages and clears the pending sequence.
`include "utf8_stream_decoder_assert.svh"
module utf8_stream_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [utf8d_pkg::BYTE_W-1:0]  in_tdata,   // [7:0] in_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [utf8d_pkg::DATA_W-1:0]  out_tdata,  // [30:0] code_point, [31] zero
  output logic                          out_tuser,  // [0] kind
  output logic                          out_tlast
);
  import utf8d_pkg::*;

  logic               in_valid_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic               consume;
  logic [1:0]         num_res;
  result_t            res0;
  result_t            res1;
  result_t            out_res;
  out_status_t        status;

  assign consume   = in_valid_r && status.room;
  assign in_tready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  utf8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_in (in_byte_r),
    .fire    (consume),
    .num_res (num_res),
    .res0    (res0),
    .res1    (res1)
  );

  utf8d_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (consume),
    .num_res   (num_res),
    .res0      (res0),
    .res1      (res1),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .status    (status)
  );

  assign out_tdata = {1'b0, out_res.code_point};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  // A word waiting in the hold register always sits behind a replacement that is not last.
  `U8D_ASSERT_SAME(a_hold_behind_first, status.hold_busy, out_tvalid && !out_tlast)
  // A control byte taken from the input register shows up next as a control word.
  `U8D_ASSERT_NEXT(a_ctrl_passes, consume && in_byte_r < 8'h20, out_tvalid && out_tuser)
  // The input side only stalls when its register is occupied.
  `U8D_ASSERT_SAME(a_stall_needs_byte, !in_tready, in_valid_r)

endmodule
